@@ src/lphm_pkg.sv @@
// lphm_pkg: shared constants, types and hash multiplier for the linear probe hash map
// no dependencies
`timescale 1ns / 1ps
package lphm_pkg;
  localparam int SLOTS = 1024;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int Q_DEPTH = 2;
  localparam logic [63:0] HASH_MULT = 64'd2654435761;
  localparam logic [9:0] LIMIT_RESET = 10'd614;

  localparam logic [1:0] OP_GET = 2'd0;
  localparam logic [1:0] OP_SET = 2'd1;
  localparam logic [1:0] OP_DEL = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_REPL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [31:0] key;
    logic [31:0] value;
    logic [IDX_W-1:0] home;
    logic legal;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] data_out;
    logic [10:0] entry_count;
  } res_t;
endpackage

@@ src/lphm_if.sv @@
// lphm_if: valid/ready channel carrying one payload of a chosen type
// depends on nothing; payload type is set where the interface is instantiated
`timescale 1ns / 1ps
interface lphm_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ src/lphm_front.sv @@
// lphm_front: accepts requests, computes home slot, queues them for the engine
// depends on lphm_pkg
`timescale 1ns / 1ps
module lphm_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_operation,
  input  logic signed [31:0] in_key,
  input  logic [31:0] in_value,
  output logic q_valid,
  input  logic q_ready,
  output lphm_pkg::cmd_t q_cmd
);
  import lphm_pkg::*;
  // stage 1 register: request with its home slot
  // the home slot needs only the low key bits of the product
  logic s1_v_r, s1_v_nxt;
  logic [1:0] s1_op_r;
  logic [31:0] s1_key_r, s1_val_r;
  logic [IDX_W-1:0] s1_home_r;
  cmd_t q_r [Q_DEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;
  logic [IDX_W-1:0] prod;
  logic push, pop;

  assign prod = in_key[IDX_W-1:0] * HASH_MULT[IDX_W-1:0];
  assign in_ready = !s1_v_r && (cnt_r == 2'd0);
  assign push = s1_v_r;
  assign pop = q_valid && q_ready;
  assign q_valid = cnt_r != 2'd0;
  assign q_cmd = q_r[rp_r];

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_valid && in_ready) s1_v_nxt = 1'b1;
    else if (push) s1_v_nxt = 1'b0;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      cnt_r <= 2'd0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      cnt_r <= cnt_nxt;
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
    end
    if (in_valid && in_ready) begin
      s1_op_r <= in_operation;
      s1_key_r <= in_key;
      s1_val_r <= in_value;
      s1_home_r <= prod;
    end
    if (push) begin
      q_r[wp_r].op <= s1_op_r;
      q_r[wp_r].key <= s1_key_r;
      q_r[wp_r].value <= s1_val_r;
      q_r[wp_r].home <= s1_home_r;
      q_r[wp_r].legal <= (s1_op_r == OP_GET) || (s1_op_r == OP_SET) || (s1_op_r == OP_DEL);
    end
  end
endmodule

@@ src/lphm_engine.sv @@
// lphm_engine: probe and backward-shift sequencer over the slot memory
// depends on lphm_pkg; holds the valid, key and value memories
`timescale 1ns / 1ps
module lphm_engine (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_ready,
  input  lphm_pkg::cmd_t q_cmd,
  input  logic [9:0] entry_limit,
  output logic out_valid,
  input  logic out_ready,
  output lphm_pkg::res_t out_res
);
  import lphm_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_CHK = 4'd2, S_SRD = 4'd3,
                         S_SCHK = 4'd4, S_SHASH = 4'd5, S_DONE = 4'd6,
                         S_CLR = 4'd7;

  logic [3:0] st_r;
  logic vld_m [SLOTS];
  logic [31:0] kmem [SLOTS];
  logic [VALUE_BITS-1:0] vmem [SLOTS];
  logic rvld_r;
  logic [31:0] rk_r;
  logic [VALUE_BITS-1:0] rv_r;
  logic [IDX_W-1:0] ptr_r, hole_r, jh_r;
  logic [CNT_W-1:0] n_r;
  logic [10:0] cnt_r;
  cmd_t c_r;
  res_t res_r;
  logic ov_r;
  logic [IDX_W-1:0] prod;
  logic [IDX_W-1:0] dh, dj;

  assign q_ready = (st_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_res = res_r;
  assign prod = rk_r[IDX_W-1:0] * HASH_MULT[IDX_W-1:0];
  // distances wrap naturally modulo the power of two table size
  assign dh = ptr_r - jh_r;
  assign dj = ptr_r - hole_r;

  always_ff @(posedge clk) begin
    rvld_r <= vld_m[ptr_r];
    rk_r <= kmem[ptr_r];
    rv_r <= vmem[ptr_r];
    if (!rst_n) begin
      st_r <= S_CLR;
      ptr_r <= '0;
      cnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (st_r)
        S_CLR: begin
          vld_m[ptr_r] <= 1'b0;
          ptr_r <= ptr_r + 1'b1;
          if (ptr_r == IDX_W'(SLOTS - 1)) st_r <= S_IDLE;
        end
        S_IDLE: if (q_valid && q_ready) begin
          c_r <= q_cmd;
          ptr_r <= q_cmd.home;
          n_r <= '0;
          if (q_cmd.legal) st_r <= S_RD;
          else begin
            res_r <= '{ST_MISS, 32'd0, cnt_r};
            st_r <= S_DONE;
          end
        end
        S_RD: st_r <= S_CHK;
        S_CHK: begin
          if (!rvld_r) begin
            if (c_r.op == OP_SET && cnt_r < {1'b0, entry_limit}) begin
              vld_m[ptr_r] <= 1'b1;
              kmem[ptr_r] <= c_r.key;
              vmem[ptr_r] <= c_r.value[VALUE_BITS-1:0];
              res_r <= '{ST_DONE, 32'd0, cnt_r + 11'd1};
              cnt_r <= cnt_r + 11'd1;
            end else res_r <= '{(c_r.op == OP_SET) ? ST_FULL : ST_MISS, 32'd0, cnt_r};
            st_r <= S_DONE;
          end else if (rk_r == c_r.key) begin
            unique case (c_r.op)
              OP_GET: begin
                res_r <= '{ST_DONE, rv_r, cnt_r};
                st_r <= S_DONE;
              end
              OP_SET: begin
                vmem[ptr_r] <= c_r.value[VALUE_BITS-1:0];
                res_r <= '{ST_REPL, rv_r, cnt_r};
                st_r <= S_DONE;
              end
              default: begin
                res_r <= '{ST_DONE, rv_r, cnt_r - 11'd1};
                cnt_r <= cnt_r - 11'd1;
                hole_r <= ptr_r;
                ptr_r <= ptr_r + 1'b1;
                n_r <= {{(CNT_W-1){1'b0}}, 1'b1};
                st_r <= S_SRD;
              end
            endcase
          end else if (n_r == CNT_W'(SLOTS - 1)) begin
            res_r <= '{(c_r.op == OP_SET) ? ST_FULL : ST_MISS, 32'd0, cnt_r};
            st_r <= S_DONE;
          end else begin
            n_r <= n_r + 1'b1;
            ptr_r <= ptr_r + 1'b1;
            st_r <= S_RD;
          end
        end
        S_SRD: st_r <= S_SHASH;
        S_SHASH: begin
          jh_r <= prod;
          st_r <= S_SCHK;
        end
        S_SCHK: begin
          if (!rvld_r || n_r == CNT_W'(SLOTS)) begin
            vld_m[hole_r] <= 1'b0;
            st_r <= S_DONE;
          end else begin
            if (dh >= dj) begin
              kmem[hole_r] <= rk_r;
              vmem[hole_r] <= rv_r;
              hole_r <= ptr_r;
            end
            ptr_r <= ptr_r + 1'b1;
            n_r <= n_r + 1'b1;
            st_r <= S_SRD;
          end
        end
        S_DONE: if (!ov_r) begin
          ov_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ src/linear_probe_hash_map.sv @@
// linear_probe_hash_map: top level, apb register, front and engine
// depends on lphm_pkg, lphm_if, lphm_front, lphm_engine
// Each probed slot takes a registered memory read and then a compare; a delete
// then repairs its run by backward shift, reading, rehashing and checking each
// slot of the run, the empty slot that ends it included. The engine takes a new
// request only once it is done with the last; a waiting result stalls the engine
// and, once one request is queued, the input. After reset a clearing pass over all
// 1024 slots empties the valid memory before the first request is served.
`timescale 1ns / 1ps
module linear_probe_hash_map (
  input  logic clk,
  input  logic rst_n,
  lphm_if.sink in_ch,
  lphm_if.source out_ch,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  import lphm_pkg::*;
  logic [9:0] limit_r;
  logic q_valid, q_ready;
  cmd_t q_cmd;
  res_t res;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {22'd0, limit_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= LIMIT_RESET;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      limit_r <= cfg_pwdata[9:0];
  end

  lphm_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_operation(in_ch.payload.operation), .in_key(in_ch.payload.key),
    .in_value(in_ch.payload.value),
    .q_valid, .q_ready, .q_cmd
  );

  lphm_engine u_engine (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd,
    .entry_limit(limit_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(res)
  );

  assign out_ch.payload.status = res.status;
  assign out_ch.payload.data_out = res.data_out;
  assign out_ch.payload.entry_count = res.entry_count;
endmodule

@@ src/lphm_checker.sv @@
// lphm_checker: port-level checks on the hash map top level
// depends on lphm_pkg; bound to linear_probe_hash_map
`timescale 1ns / 1ps
module lphm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_status,
  input logic [10:0] out_entry_count
);
  import lphm_pkg::*;
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status)) else $error("status changed");
  a_no_accept_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second request too soon");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= 11'(SLOTS)) else $error("count out of range");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");
endmodule

bind linear_probe_hash_map lphm_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.payload.status), .out_entry_count(out_ch.payload.entry_count)
);

@@ bench/lphm_tb_if.sv @@
// lphm_tb_if: request payload type used by the bench on the input channel
// depends on nothing; the channel interface itself comes from src/lphm_if.sv
`timescale 1ns / 1ps
package lphm_tb_pkg;
  typedef struct packed {
    logic [1:0] operation;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;
endpackage

@@ bench/tb_linear_probe_hash_map.sv @@
// tb_linear_probe_hash_map: self-checking bench for the linear probe hash map
// depends on lphm_pkg, lphm_if, lphm_tb_pkg; predicts every response and compares in order
`timescale 1ns / 1ps
module tb_linear_probe_hash_map;
  import lphm_pkg::*;
  import lphm_tb_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [1:0] REG_LIMIT = 2'd0;

  typedef bit bool_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  lphm_if #(.T(req_t)) in_if ();
  lphm_if #(.T(res_t)) out_if ();

  linear_probe_hash_map i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  // predicted table
  logic tbl_valid [SLOTS];
  logic [31:0] tbl_key [SLOTS];
  logic [31:0] tbl_val [SLOTS];
  int held;
  int limit_now;

  res_t pending_resp [$];
  int fails = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  logic [31:0] near_keys [$];

  function automatic int home_of(logic [31:0] k);
    logic [63:0] x;
    x = {{32{k[31]}}, k} * HASH_MULT;
    return int'(x[IDX_W-1:0]);
  endfunction

  function automatic int gap(int from, int to);
    return (to >= from) ? to - from : to + SLOTS - from;
  endfunction

  function automatic void remove_slot(int hole);
    int j;
    j = (hole + 1) % SLOTS;
    for (int n = 1; n < SLOTS; n++) begin
      if (!tbl_valid[j]) break;
      if (gap(home_of(tbl_key[j]), j) >= gap(hole, j)) begin
        tbl_key[hole] = tbl_key[j];
        tbl_val[hole] = tbl_val[j];
        tbl_valid[hole] = 1'b1;
        hole = j;
      end
      j = (j + 1) % SLOTS;
    end
    tbl_valid[hole] = 1'b0;
  endfunction

  function automatic res_t predict_map(req_t r);
    res_t o;
    int s, where;
    bool_t hit, empty_ok;
    o.status = ST_MISS;
    o.data_out = '0;
    hit = 0;
    empty_ok = 0;
    where = 0;
    if (r.operation != OP_NONE) begin
      s = home_of(r.key);
      for (int n = 0; n < SLOTS; n++) begin
        if (!tbl_valid[s]) begin
          where = s;
          empty_ok = 1;
          break;
        end
        if (tbl_key[s] == r.key) begin
          where = s;
          hit = 1;
          break;
        end
        s = (s + 1) % SLOTS;
      end
      case (r.operation)
        OP_GET: begin
          if (hit) begin
            o.status = ST_DONE;
            o.data_out = tbl_val[where];
          end
        end
        OP_SET: begin
          if (hit) begin
            o.status = ST_REPL;
            o.data_out = tbl_val[where];
            tbl_val[where] = r.value;
          end else if (!empty_ok || held >= limit_now) begin
            o.status = ST_FULL;
          end else begin
            tbl_valid[where] = 1'b1;
            tbl_key[where] = r.key;
            tbl_val[where] = r.value;
            held++;
            o.status = ST_DONE;
          end
        end
        default: begin
          if (hit) begin
            o.status = ST_DONE;
            o.data_out = tbl_val[where];
            remove_slot(where);
            if (held > 0) held--;
          end
        end
      endcase
    end
    o.entry_count = 11'(held);
    return o;
  endfunction

  // response side: ready with random stalls, long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    res_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_resp.size() == 0) begin
        $error("response with none expected: %p", out_if.payload);
        fails++;
      end else begin
        exp_r = pending_resp.pop_front();
        if (out_if.payload.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_if.payload.status);
          fails++;
        end
        if (out_if.payload.data_out !== exp_r.data_out) begin
          $error("data_out: expected %h, got %h", exp_r.data_out, out_if.payload.data_out);
          fails++;
        end
        if (out_if.payload.entry_count !== exp_r.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.entry_count,
                 out_if.payload.entry_count);
          fails++;
        end
      end
    end
  end

  task automatic send_req(logic [1:0] op, logic [31:0] key, logic [31:0] value);
    req_t r;
    r = '{operation: op, key: key, value: value};
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= r;
    do @(posedge clk); while (!in_if.ready);
    pending_resp.push_back(predict_map(r));
  endtask

  task automatic drain();
    @(posedge clk);
    in_if.valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] v);
    drain();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_LIMIT;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    limit_now = int'(v[9:0]);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    int c;
    c = $urandom_range(99);
    if (c < 70) return near_keys[$urandom_range(near_keys.size() - 1)];
    if (c < 80) return (32'($urandom_range(7)) - 32'd4) ^ {1'($urandom_range(1)), 31'd0};
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_op();
    int c;
    c = $urandom_range(99);
    if (c < 45) return OP_SET;
    if (c < 75) return OP_GET;
    if (c < 95) return OP_DEL;
    return OP_NONE;
  endfunction

  task automatic test_directed();
    send_req(OP_GET, 32'h0, 32'h0);
    send_req(OP_SET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_req(OP_SET, 32'h7FFF_FFFF, 32'h0);
    send_req(OP_SET, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
    send_req(OP_SET, 32'h0, 32'h5A5A_A5A5);
    send_req(OP_GET, 32'h8000_0000, 32'h1234_5678);
    send_req(OP_GET, 32'h7FFF_FFFF, 32'h0);
    send_req(OP_SET, 32'h8000_0000, 32'h0000_0001);
    send_req(OP_GET, 32'h8000_0000, 32'h0);
    send_req(OP_NONE, 32'h0, 32'hFFFF_FFFF);
    send_req(OP_DEL, 32'hFFFF_FFFF, 32'h0);
    send_req(OP_DEL, 32'hFFFF_FFFF, 32'h0);
    for (int i = 0; i < 6; i++) send_req(OP_SET, near_keys[i], 32'(i));
    send_req(OP_DEL, near_keys[1], 32'h0);
    for (int i = 0; i < 6; i++) send_req(OP_GET, near_keys[i], 32'h0);
  endtask

  task automatic test_limit();
    write_limit(32'd2);
    send_req(OP_SET, 32'h1111_1111, 32'h1);
    send_req(OP_SET, 32'h2222_2222, 32'h2);
    send_req(OP_SET, 32'h7FFF_FFFF, 32'h3);
    send_req(OP_SET, 32'h0, 32'h4);
    write_limit(32'd0);
    send_req(OP_SET, 32'h3333_3333, 32'h5);
    send_req(OP_DEL, 32'h0, 32'h0);
    send_req(OP_SET, 32'h3333_3333, 32'h6);
    write_limit(32'd1);
    send_req(OP_SET, 32'h4444_4444, 32'h7);
    write_limit(32'd1023);
  endtask

  task automatic test_random(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) send_req(pick_op(), pick_key(), $urandom);
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_cycles = 300;
    for (int i = 0; i < 40; i++) send_req(pick_op(), pick_key(), $urandom);
    drain();
  endtask

  initial begin
    logic [31:0] k;
    in_if.valid <= 1'b0;
    in_if.payload <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    rst_n <= 1'b0;
    for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
    held = 0;
    limit_now = int'(LIMIT_RESET);
    while (near_keys.size() < 48) begin
      k = $urandom;
      if (home_of(k) < 8 || home_of(k) > SLOTS - 4) near_keys.push_back(k);
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_limit();
    test_random(120, 0, 0);
    write_limit(32'd40);
    test_random(100, 72, 0);
    write_limit(32'd614);
    test_random(100, 0, 72);
    test_random(90, 8, 8);
    test_backpressure();
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
